[hdl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

  // Default number of queue entries
  localparam int unsigned DEFAULT_DEPTH = 16;

  // Field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  // Operation codes carried on the input tuser bit
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_e;

  // Result status codes carried on the output tuser bits
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_CMP,
    S_DEL_RD,
    S_DEL_CAP,
    S_REPLY
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  load;     // capture the accepted transaction
    logic  rd_prev;  // read the entry just ahead of the insert position
    logic  rd_head;  // read the head entry
    logic  wr_new;   // write the new entry at the insert position
    logic  wr_prev;  // move the entry read last one slot back
    logic  del_cap;  // capture the head entry and drop it from the queue
    logic  reply;    // load the output register
    stat_e code;     // status reported with the reply
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic op_del;    // captured operation is a delete
    logic full;      // queue holds its full depth
    logic empty;     // queue holds nothing
    logic at_head;   // insert position reached the head
    logic prev_le;   // entry read last has priority <= new priority
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

[hdl/spq_ctrl.sv]
`timescale 1ns / 1ps

module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  spq_pkg::sts_t sts_i,
  output spq_pkg::cmd_t cmd_o
);

  spq_pkg::state_e state_q, state_d;
  spq_pkg::stat_e  code_q, code_d;

  // Hold state and pending status code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::S_IDLE;
      code_q  <= spq_pkg::STAT_DONE;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    unique case (state_q)
      spq_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = spq_pkg::S_DECODE;
        end
      end
      spq_pkg::S_DECODE: begin
        if (sts_i.op_del) begin
          if (sts_i.empty) begin
            state_d = spq_pkg::S_REPLY;
            code_d  = spq_pkg::STAT_EMPTY;
          end else begin
            state_d = spq_pkg::S_DEL_RD;
          end
        end else begin
          if (sts_i.full) begin
            state_d = spq_pkg::S_REPLY;
            code_d  = spq_pkg::STAT_FULL;
          end else begin
            state_d = spq_pkg::S_INS_RD;
          end
        end
      end
      spq_pkg::S_INS_RD: begin
        if (sts_i.at_head) begin
          state_d = spq_pkg::S_REPLY;
          code_d  = spq_pkg::STAT_DONE;
        end else begin
          state_d = spq_pkg::S_INS_CMP;
        end
      end
      spq_pkg::S_INS_CMP: begin
        if (sts_i.prev_le) begin
          state_d = spq_pkg::S_REPLY;
          code_d  = spq_pkg::STAT_DONE;
        end else begin
          state_d = spq_pkg::S_INS_RD;
        end
      end
      spq_pkg::S_DEL_RD: begin
        state_d = spq_pkg::S_DEL_CAP;
      end
      spq_pkg::S_DEL_CAP: begin
        state_d = spq_pkg::S_REPLY;
        code_d  = spq_pkg::STAT_DONE;
      end
      spq_pkg::S_REPLY: begin
        if (sts_i.out_free) begin
          state_d = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.code    = code_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      spq_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
      end
      spq_pkg::S_DECODE: begin
      end
      spq_pkg::S_INS_RD: begin
        if (sts_i.at_head) begin
          cmd_o.wr_new = 1'b1;
        end else begin
          cmd_o.rd_prev = 1'b1;
        end
      end
      spq_pkg::S_INS_CMP: begin
        if (sts_i.prev_le) begin
          cmd_o.wr_new = 1'b1;
        end else begin
          cmd_o.wr_prev = 1'b1;
        end
      end
      spq_pkg::S_DEL_RD: begin
        cmd_o.rd_head = 1'b1;
      end
      spq_pkg::S_DEL_CAP: begin
        cmd_o.del_cap = 1'b1;
      end
      spq_pkg::S_REPLY: begin
        cmd_o.reply = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[hdl/spq_dp.sv]
`timescale 1ns / 1ps

module spq_dp #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          op_i,
  input  logic signed [spq_pkg::DATA_W-1:0] item_value_i,
  input  logic signed [spq_pkg::DATA_W-1:0] item_priority_i,
  input  spq_pkg::cmd_t                 cmd_i,
  output spq_pkg::sts_t                 sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output spq_pkg::stat_e                status_o,
  output logic signed [spq_pkg::DATA_W-1:0] removed_value_o,
  output logic signed [spq_pkg::DATA_W-1:0] removed_priority_o,
  output logic [spq_pkg::OCC_W-1:0]     occupancy_o
);

  localparam int unsigned AW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DW  = spq_pkg::DATA_W;
  localparam int unsigned MW  = 2 * DW;
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  // Entry store, ring addressed: {priority, value}
  logic [MW-1:0] mem [QUEUE_DEPTH];

  logic [AW-1:0] hd_q, tl_q, pos_q;
  logic [CW-1:0] cnt_q;
  logic          op_q;
  logic          out_valid_q;
  logic signed [DW-1:0] new_val_q, new_pri_q;
  logic signed [DW-1:0] rd_val_q, rd_pri_q;
  logic signed [DW-1:0] rem_val_q, rem_pri_q;
  spq_pkg::stat_e       out_stat_q;
  logic signed [DW-1:0] out_val_q, out_pri_q;
  logic [spq_pkg::OCC_W-1:0] out_occ_q;

  logic [AW-1:0] prev_pos, hd_inc, tl_inc, rd_addr, wr_addr;
  logic          rd_en, wr_en;
  logic [MW-1:0] wr_data;

  // Ring pointer steps
  assign prev_pos = (pos_q == '0) ? LAST : pos_q - AW'(1);
  assign hd_inc   = (hd_q == LAST) ? '0 : hd_q + AW'(1);
  assign tl_inc   = (tl_q == LAST) ? '0 : tl_q + AW'(1);

  // Memory port selection
  assign rd_en   = cmd_i.rd_prev | cmd_i.rd_head;
  assign rd_addr = cmd_i.rd_head ? hd_q : prev_pos;
  assign wr_en   = cmd_i.wr_new | cmd_i.wr_prev;
  assign wr_addr = pos_q;
  assign wr_data = cmd_i.wr_new ? {new_pri_q, new_val_q} : {rd_pri_q, rd_val_q};

  // Write and registered read of the entry store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      {rd_pri_q, rd_val_q} <= mem[rd_addr];
    end
  end

  // Ring pointers, count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_q        <= '0;
      tl_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_new) begin
        tl_q  <= tl_inc;
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.del_cap) begin
        hd_q  <= hd_inc;
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.reply) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the transaction, walk the insert position, build the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_i;
      new_val_q <= item_value_i;
      new_pri_q <= item_priority_i;
      pos_q     <= tl_q;
      rem_val_q <= '0;
      rem_pri_q <= '0;
    end
    if (cmd_i.wr_prev) begin
      pos_q <= prev_pos;
    end
    if (cmd_i.del_cap) begin
      rem_val_q <= rd_val_q;
      rem_pri_q <= rd_pri_q;
    end
    if (cmd_i.reply) begin
      out_stat_q <= cmd_i.code;
      out_val_q  <= rem_val_q;
      out_pri_q  <= rem_pri_q;
      out_occ_q  <= spq_pkg::OCC_W'(cnt_q);
    end
  end

  // Status toward the controller
  assign sts_o.op_del   = (op_q == spq_pkg::OP_DELETE);
  assign sts_o.full     = (cnt_q == CW'(QUEUE_DEPTH));
  assign sts_o.empty    = (cnt_q == '0);
  assign sts_o.at_head  = (pos_q == hd_q);
  assign sts_o.prev_le  = (rd_pri_q <= new_pri_q);
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_stat_q;
  assign removed_value_o    = out_val_q;
  assign removed_priority_o = out_pri_q;
  assign occupancy_o        = out_occ_q;

endmodule

[hdl/sorted_priority_queue.sv]
`timescale 1ns / 1ps

// Stable minimum priority queue of QUEUE_DEPTH entries, each a 32-bit data word
// and a signed 32-bit priority; the smallest priority leaves first and equal
// priorities leave in arrival order. tuser 0 inserts the entry in tdata, tuser 1
// removes the head and returns it. Every transaction gives one result: status
// done, empty (delete on an empty queue) or full (insert dropped). One
// transaction is handled at a time; entries sit in a single-port ring memory and
// an insert walks from the tail toward the head, moving each held entry of greater
// priority one slot back with a read and then a write. The input takes the next
// transaction as soon as the result is loaded, while that result still waits in
// the output register.
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DEFAULT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // item_value [31:0], item_priority [63:32]
  input  logic        s_axis_tuser,  // operation [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // removed_value [31:0], removed_priority [63:32],
                                     // occupancy [68:64], zero [71:69]
  output logic [1:0]  m_axis_tuser   // status [1:0]
);

  spq_pkg::cmd_t  cmd;
  spq_pkg::sts_t  sts;
  spq_pkg::stat_e status;
  logic signed [spq_pkg::DATA_W-1:0] removed_value, removed_priority;
  logic [spq_pkg::OCC_W-1:0] occupancy;

  // Sequencer
  spq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Entry store, pointers and output register
  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .op_i               (s_axis_tuser),
    .item_value_i       (s_axis_tdata[31:0]),
    .item_priority_i    (s_axis_tdata[63:32]),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .status_o           (status),
    .removed_value_o    (removed_value),
    .removed_priority_o (removed_priority),
    .occupancy_o        (occupancy)
  );

  // Pack the result transaction
  assign m_axis_tdata = {3'b000, occupancy, removed_priority, removed_value};
  assign m_axis_tuser = status;

  // One transaction at a time: input closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a transaction is in progress");

  // Never load a new result over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.reply |-> !m_axis_tvalid || m_axis_tready)
    else $error("result register overwritten");

  // An empty delete reports zero fields and zero occupancy
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == spq_pkg::STAT_EMPTY) |->
      (m_axis_tdata == '0))
    else $error("empty delete returned nonzero fields");

  // A dropped insert reports a full queue
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == spq_pkg::STAT_FULL) |->
      (m_axis_tdata[68:64] == spq_pkg::OCC_W'(QUEUE_DEPTH)) &&
      (m_axis_tdata[63:0] == '0))
    else $error("dropped insert with wrong occupancy or fields");

endmodule

[tb/sv/tb_sorted_priority_queue.sv]
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

  localparam int unsigned DEPTH       = spq_pkg::DEFAULT_DEPTH;
  localparam int unsigned RAND_OPS    = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned HOLD_AFTER  = 150;
  localparam int unsigned HOLD_CYCLES = 300;

  // One queued operation for the input stream
  typedef struct {
    spq_pkg::op_e   op;
    logic [31:0]    val;
    logic [31:0]    prio;
  } queue_op_t;

  // One predicted reply
  typedef struct {
    spq_pkg::stat_e status;
    logic [31:0]    val;
    logic [31:0]    prio;
    logic [4:0]     occ;
  } reply_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;  // item_value [31:0], item_priority [63:32]
  logic        s_axis_tuser  = 1'b0;  // operation [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;  // removed_value [31:0], removed_priority [63:32],
                              // occupancy [68:64], zero [71:69]
  logic [1:0]  m_axis_tuser;  // status [1:0]

  queue_op_t   queued_ops[$];
  reply_t      due_replies[$];
  logic [31:0] held_val[$];
  logic [31:0] held_prio[$];

  int unsigned err_cnt      = 0;
  int unsigned replies_seen = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;

  sorted_priority_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Print one mismatch line and count it
  task automatic flag_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  // Apply one operation to the sorted list and queue the reply it gives
  task automatic queue_model_apply(input spq_pkg::op_e op, input logic [31:0] val,
                                   input logic [31:0] prio);
    reply_t r;
    int     pos;
    r.status = spq_pkg::STAT_DONE;
    r.val    = '0;
    r.prio   = '0;
    if (op == spq_pkg::OP_INSERT) begin
      if (held_val.size() >= DEPTH) begin
        r.status = spq_pkg::STAT_FULL;
      end else begin
        // go behind every entry of lower or equal priority
        pos = 0;
        while (pos < held_prio.size() && $signed(held_prio[pos]) <= $signed(prio))
          pos++;
        held_val.insert(pos, val);
        held_prio.insert(pos, prio);
      end
    end else if (held_val.size() == 0) begin
      r.status = spq_pkg::STAT_EMPTY;
    end else begin
      r.val  = held_val.pop_front();
      r.prio = held_prio.pop_front();
    end
    r.occ = 5'(held_val.size());
    due_replies.push_back(r);
  endtask

  // Compare one reply transaction against the oldest prediction
  task automatic check_reply();
    reply_t w;
    if (due_replies.size() == 0) begin
      flag_mismatch($sformatf("reply with nothing due: tuser %0d tdata %h",
                              m_axis_tuser, m_axis_tdata));
      return;
    end
    w = due_replies.pop_front();
    if (m_axis_tuser != w.status)
      flag_mismatch($sformatf("status got %0d want %0d", m_axis_tuser, w.status));
    if (m_axis_tdata[31:0] != w.val)
      flag_mismatch($sformatf("removed value got %h want %h", m_axis_tdata[31:0], w.val));
    if (m_axis_tdata[63:32] != w.prio)
      flag_mismatch($sformatf("removed priority got %h want %h",
                              m_axis_tdata[63:32], w.prio));
    if (m_axis_tdata[68:64] != w.occ)
      flag_mismatch($sformatf("occupancy got %0d want %0d", m_axis_tdata[68:64], w.occ));
    if (m_axis_tdata[71:69] != 3'b000)
      flag_mismatch($sformatf("pad bits got %b", m_axis_tdata[71:69]));
  endtask

  // Mostly short idles, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    else if (roll < 88) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Priorities: many ties in a narrow band, plus wide and extreme values
  function automatic logic [31:0] pick_prio();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 32'($signed($urandom_range(0, 7)) - 4);
    else if (roll < 75) return $urandom;
    else if (roll < 85) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    else if (roll < 93) return 32'h8000_0000 + $urandom_range(0, 3);
    else return 32'h7fff_ffff - $urandom_range(0, 3);
  endfunction

  task automatic add_op(input spq_pkg::op_e op, input logic [31:0] val,
                        input logic [31:0] prio);
    queue_op_t q;
    q.op   = op;
    q.val  = val;
    q.prio = prio;
    queued_ops.push_back(q);
  endtask

  // Driver: present queued operations with random idles
  always @(posedge clk_i or negedge rst_ni) begin
    queue_op_t q;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        queue_model_apply(spq_pkg::op_e'(s_axis_tuser), s_axis_tdata[31:0],
                          s_axis_tdata[63:32]);
      // advance only once the current transaction is gone
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (queued_ops.size() != 0) begin
          q = queued_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= q.op;
          s_axis_tdata  <= {q.prio, q.val};
          gap_left      <= pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off on the reply side, once, to back up the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && replies_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: take replies with random stalls and check them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_reply();
        replies_seen <= replies_seen + 1;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 20) begin
        stall_left    <= pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sorted_priority_queue: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned phase_left;
    int unsigned insert_pct;
    int unsigned n;

    // delete from the empty queue
    add_op(spq_pkg::OP_DELETE, 32'h1234_5678, 32'h8765_4321);
    // extremes of value and priority, then ties at the ends and in the middle
    add_op(spq_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    add_op(spq_pkg::OP_INSERT, 32'hffff_ffff, 32'h7fff_ffff);
    add_op(spq_pkg::OP_INSERT, 32'h8000_0000, 32'h8000_0000);
    add_op(spq_pkg::OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
    add_op(spq_pkg::OP_INSERT, 32'h0000_0001, 32'h0000_0005);
    add_op(spq_pkg::OP_INSERT, 32'h0000_0002, 32'h0000_0005);
    add_op(spq_pkg::OP_INSERT, 32'h0000_0003, 32'h0000_0005);
    add_op(spq_pkg::OP_INSERT, 32'haaaa_aaaa, 32'h8000_0000);
    add_op(spq_pkg::OP_INSERT, 32'h5555_5555, 32'h7fff_ffff);
    add_op(spq_pkg::OP_INSERT, 32'h0000_0004, 32'h0000_0001);
    // fill to the last free slot
    for (n = 0; n < 6; n++)
      add_op(spq_pkg::OP_INSERT, $urandom, pick_prio());
    // insert into a full queue
    add_op(spq_pkg::OP_INSERT, 32'hdead_beef, 32'h8000_0000);
    // deletes carry operand fields that must be ignored
    for (n = 0; n < 4; n++)
      add_op(spq_pkg::OP_DELETE, $urandom, $urandom);

    // random phases that lean toward filling, draining or a mix
    phase_left = 0;
    insert_pct = 50;
    for (n = 0; n < RAND_OPS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      phase_left--;
      if ($urandom_range(0, 99) < insert_pct)
        add_op(spq_pkg::OP_INSERT, $urandom, pick_prio());
      else
        add_op(spq_pkg::OP_DELETE, $urandom, $urandom);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for all transactions to go out and all replies to come back
    do @(negedge clk_i);
    while (queued_ops.size() != 0 || s_axis_tvalid || due_replies.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (err_cnt == 0) begin
      $display("sorted_priority_queue: match");
    end else begin
      $display("sorted_priority_queue: mismatch");
    end
    $finish;
  end

endmodule
